### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  // queue depth and derived widths
  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int TIME_W   = 16;
  localparam int ECOUNT_W = 5;
  localparam int STATUS_W = 2;

  // operation carried in the input tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] duration;
  } entry_t;

  // broadcast control to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t din;
  } cell_ctl_t;

endpackage

### hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Fixed-depth priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one insert or pop transaction per clock and returns one result
// transaction for each, loaded on acceptance into an output
// register; the input stalls only while that register is full and not taken.
// Every cell compares its priority with the new entry and shifts or holds in
// the same cycle, and the whole row of cells updates together. The
// result shows the head entry and count after the operation; an insert into
// a full queue is dropped with status full, a pop of an empty queue reports
// status empty. Equal priorities leave in arrival order.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // id[15:0], priority[23:16], arrival[39:24], duration[55:40]
  input  logic        in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // id[15:0], priority[23:16], arrival[39:24],
                                 // duration[55:40], entry_count[60:56], zero[63:61]
  output logic [2:0]  out_tuser  // head_valid[0], status[2:1]
);

  localparam int N = spq_pkg::DEPTH;

  logic [spq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_tvalid_r;
  spq_pkg::entry_t           head_r;
  logic                      head_valid_r;
  logic [spq_pkg::CNT_W-1:0] head_count_r;
  spq_pkg::status_t          status_r, status_nxt;

  logic                      in_accept;
  logic                      full, empty;
  spq_pkg::cell_ctl_t        ctl;
  spq_pkg::entry_t           cell_q   [N];
  spq_pkg::entry_t           cell_nxt [N];
  logic [N-1:0]              cell_keeps;

  // handshake
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // broadcast control
  assign full  = (count_r == spq_pkg::CNT_W'(N));
  assign empty = (count_r == '0);

  always_comb begin
    ctl.din.id       = in_tdata[15:0];
    ctl.din.prio     = in_tdata[23:16];
    ctl.din.arrival  = in_tdata[39:24];
    ctl.din.duration = in_tdata[55:40];
    ctl.ins = in_accept && (spq_pkg::op_t'(in_tuser) == spq_pkg::OP_INSERT) && !full;
    ctl.pop = in_accept && (spq_pkg::op_t'(in_tuser) == spq_pkg::OP_POP) && !empty;
  end

  // cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            occ;
    logic            lk;
    spq_pkg::entry_t le, re;

    assign occ = (spq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign le = ctl.din;
    end else begin : g_mid
      assign lk = cell_keeps[i-1];
      assign le = cell_q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign re = cell_q[i];
    end else begin : g_body
      assign re = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .left_keeps  (lk),
      .left_entry  (le),
      .right_entry (re),
      .entry       (cell_q[i]),
      .entry_nxt   (cell_nxt[i]),
      .keeps       (cell_keeps[i])
    );
  end

  // count and status
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
    if (spq_pkg::op_t'(in_tuser) == spq_pkg::OP_INSERT) begin
      if (full) status_nxt = spq_pkg::ST_FULL;
    end else begin
      if (empty) status_nxt = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      head_valid_r <= (count_nxt != '0);
      head_r       <= (count_nxt != '0) ? cell_nxt[0] : '0;
      head_count_r <= count_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000,
                       spq_pkg::ECOUNT_W'(head_count_r),
                       head_r.duration,
                       head_r.arrival,
                       head_r.prio,
                       head_r.id};
  assign out_tuser  = {status_r, head_valid_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(N))
    else $error("queue count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted insert did not grow the queue");

  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (head_valid_r == (head_count_r != '0)))
    else $error("head flag disagrees with result count");

  a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= spq_pkg::CNT_W'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
    else $error("front cells out of priority order");

endmodule

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, loads the new entry or shifts from a
// neighbor depending on the broadcast operation and its own compare.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_keeps,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_nxt,
  output logic               keeps
);

  spq_pkg::entry_t entry_r;

  // a stored entry of equal or higher priority stays in front of the new one
  assign keeps = occupied && (entry_r.prio >= ctl.din.prio);

  // next slot content
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = right_entry;
    end else if (ctl.ins && !keeps) begin
      entry_nxt = left_keeps ? ctl.din : left_entry;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue stream block.
// ----------------------------------------------------------------------------
// A directed table covers the empty queue, the field extremes, equal
// priorities, a full queue and a pop whose entry fields are junk. Random
// insert/pop transactions follow. The inserts and pops alternate in heavy
// runs so that the queue keeps swinging between full and empty. Each accepted
// transaction is run through a local sorted-store model, and the expected
// head/count/status is queued. Every result transaction is compared field by
// field with the oldest expected one. Both sides idle at random, and the
// receiver holds off once for a long stretch to back the block up.
module testbench;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 530;
  localparam int HEAVY_RUN     = 40;
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int PRINT_LIMIT   = 40;
  localparam int DIRECTED_ROWS = 11;

  // expected contents of one result transaction
  typedef struct packed {
    logic                         head_valid;
    spq_pkg::entry_t              head;
    logic [spq_pkg::ECOUNT_W-1:0] count;
    spq_pkg::status_t             status;
  } head_result_t;

  // per-transaction choice between a typed-in result and the model
  typedef struct packed {
    logic         fixed;
    head_result_t want;
  } typed_result_t;

  // one row of the directed table
  typedef struct {
    spq_pkg::op_t    op;
    spq_pkg::entry_t e;
    int              reps;
    logic            fixed;
    head_result_t    want;
  } directed_row_t;

  localparam spq_pkg::entry_t ENTRY_MAX  = '{16'hffff, 8'hff, 16'hffff, 16'hffff};
  localparam spq_pkg::entry_t ENTRY_ZERO = '0;
  localparam head_result_t    FROM_MODEL = '0;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [55:0]         in_tdata   = '0;   // id, priority, arrival, duration
  spq_pkg::op_t        in_tuser   = spq_pkg::OP_INSERT; // opcode
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [63:0]         out_tdata;         // id, priority, arrival, duration, count, zero
  logic [2:0]          out_tuser;         // head_valid, status

  // model of the sorted store
  spq_pkg::entry_t     sorted_store [spq_pkg::DEPTH];
  int                  stored_n = 0;

  head_result_t        pending_heads [$];
  typed_result_t       typed_results [$];
  int                  errors       = 0;
  int                  tx_idle_pct  = 0;
  int                  rx_idle_pct  = 0;
  bit                  stall_request = 1'b0;
  int                  quiet_cycles = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // pop of the empty queue
    '{spq_pkg::OP_POP,    ENTRY_ZERO, 1, 1'b1,
      '{1'b0, ENTRY_ZERO, 5'd0, spq_pkg::ST_EMPTY}},
    // all-ones entry becomes the head
    '{spq_pkg::OP_INSERT, ENTRY_MAX,  1, 1'b1,
      '{1'b1, ENTRY_MAX, 5'd1, spq_pkg::ST_OK}},
    // all-zero entry sorts behind it
    '{spq_pkg::OP_INSERT, ENTRY_ZERO, 1, 1'b1,
      '{1'b1, ENTRY_MAX, 5'd2, spq_pkg::ST_OK}},
    // equal top priority stays behind the older entry
    '{spq_pkg::OP_INSERT, '{16'h1234, 8'hff, 16'h0001, 16'h0002}, 1, 1'b1,
      '{1'b1, ENTRY_MAX, 5'd3, spq_pkg::ST_OK}},
    // middle priorities, ties in arrival order
    '{spq_pkg::OP_INSERT, '{16'h0001, 8'h80, 16'h5555, 16'haaaa}, 1, 1'b0, FROM_MODEL},
    '{spq_pkg::OP_INSERT, '{16'h0002, 8'h80, 16'haaaa, 16'h5555}, 1, 1'b0, FROM_MODEL},
    // fill up to the full depth
    '{spq_pkg::OP_INSERT, '{16'h0003, 8'h7f, 16'h00ff, 16'hff00}, 11, 1'b0, FROM_MODEL},
    // insert into the full queue is dropped
    '{spq_pkg::OP_INSERT, '{16'hbeef, 8'hff, 16'h0000, 16'hffff}, 1, 1'b1,
      '{1'b1, ENTRY_MAX, 5'd16, spq_pkg::ST_FULL}},
    // pop with junk entry fields
    '{spq_pkg::OP_POP,    ENTRY_MAX,  1, 1'b0, FROM_MODEL},
    '{spq_pkg::OP_POP,    ENTRY_ZERO, 3, 1'b0, FROM_MODEL},
    '{spq_pkg::OP_INSERT, '{16'ha5a5, 8'h01, 16'h5a5a, 16'hc3c3}, 1, 1'b0, FROM_MODEL}
  };

  sorted_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // apply one operation to the store model and return the head it leaves
  function automatic head_result_t next_head_result(spq_pkg::op_t op, spq_pkg::entry_t e);
    head_result_t r;
    int           pos;
    r        = '0;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (stored_n >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < stored_n && sorted_store[pos].prio >= e.prio) pos++;
        for (int i = stored_n; i > pos; i--) sorted_store[i] = sorted_store[i-1];
        sorted_store[pos] = e;
        stored_n++;
      end
    end else begin
      if (stored_n == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        for (int i = 0; i + 1 < stored_n; i++) sorted_store[i] = sorted_store[i+1];
        stored_n--;
      end
    end
    r.head_valid = (stored_n > 0);
    r.head       = (stored_n > 0) ? sorted_store[0] : ENTRY_ZERO;
    r.count      = spq_pkg::ECOUNT_W'(stored_n);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
  endtask

  // offer one transaction, idling first at the current sender rate
  task automatic offer_item(spq_pkg::op_t op, spq_pkg::entry_t e, logic fixed,
                            head_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    typed_results.push_back('{fixed, want});
    in_tuser  <= op;
    in_tdata  <= {e.duration, e.arrival, e.prio, e.id};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: random backpressure, plus one long hold on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // predict on every accepted input, check every accepted result
  always @(posedge clk) begin : result_monitor
    spq_pkg::entry_t e;
    head_result_t    want;
    typed_result_t   typed;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        e.id       = in_tdata[15:0];
        e.prio     = in_tdata[23:16];
        e.arrival  = in_tdata[39:24];
        e.duration = in_tdata[55:40];
        want  = next_head_result(in_tuser, e);
        typed = typed_results.pop_front();
        pending_heads.push_back(typed.fixed ? typed.want : want);
      end
      if (out_tvalid && out_tready) begin
        if (pending_heads.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = pending_heads.pop_front();
          if (out_tuser[0] !== want.head_valid)
            report_mismatch("head_valid", out_tuser[0], want.head_valid);
          if (out_tdata[15:0] !== want.head.id)
            report_mismatch("head_id", out_tdata[15:0], want.head.id);
          if (out_tdata[23:16] !== want.head.prio)
            report_mismatch("head_priority", out_tdata[23:16], want.head.prio);
          if (out_tdata[39:24] !== want.head.arrival)
            report_mismatch("head_arrival", out_tdata[39:24], want.head.arrival);
          if (out_tdata[55:40] !== want.head.duration)
            report_mismatch("head_duration", out_tdata[55:40], want.head.duration);
          if (out_tdata[60:56] !== want.count)
            report_mismatch("entry_count", out_tdata[60:56], want.count);
          if (out_tdata[63:61] !== 3'b000)
            report_mismatch("pad bits", out_tdata[63:61], 0);
          if (out_tuser[2:1] !== want.status)
            report_mismatch("status", out_tuser[2:1], want.status);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("sorted_priority_queue: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    spq_pkg::entry_t e;
    spq_pkg::op_t    op;
    bit              insert_heavy;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sender sparse idling, receiver mostly stalled
    tx_idle_pct = 8;
    rx_idle_pct = 87;

    // directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        offer_item(directed_rows[r].op, directed_rows[r].e,
                   directed_rows[r].fixed, directed_rows[r].want);
    end

    // random transactions in alternating insert-heavy and pop-heavy runs
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 87;
        rx_idle_pct = 8;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_request = 1'b1;
      end
      insert_heavy = ((n / HEAVY_RUN) % 2 == 0);
      op = ($urandom_range(99) < (insert_heavy ? 75 : 25)) ?
           spq_pkg::OP_INSERT : spq_pkg::OP_POP;
      e.id       = 16'($urandom);
      e.prio     = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
      e.arrival  = 16'($urandom);
      e.duration = 16'($urandom);
      offer_item(op, e, 1'b0, FROM_MODEL);
    end
    in_tvalid <= 1'b0;

    // drain outstanding results
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_heads.size() == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
